// ===== src/vsc_pkg.sv =====
// ----------------------------------------------------------------------------
// vsc_pkg
// shared types and constants of the variable-length size codec
// ----------------------------------------------------------------------------
package vsc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CHUNK_W   = 7;
  localparam int unsigned VAL_W     = 56;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned MAX_CHUNK = 8;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned QDEPTH    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_DECODE = 2'd1,
    REQ_ENCODE = 2'd2
  } req_e;

  typedef struct packed {
    logic             enc;
    logic             accepted;
    logic             complete;
    logic [VAL_W-1:0] size_value;
    logic [CNT_W-1:0] byte_count;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } enq_t;

  function automatic logic [CNT_W-1:0] enc_len(input logic [VAL_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = CNT_W'(1);
    for (int k = 1; k < MAX_CHUNK; k++) begin
      if ((v >> (CHUNK_W * k)) != '0) n = CNT_W'(k + 1);
    end
    return n;
  endfunction

endpackage

// ===== src/vsc_if.sv =====
// ----------------------------------------------------------------------------
// vsc_req_if / vsc_rsp_if
// valid/ready channels for codec requests and result beats
// ----------------------------------------------------------------------------
interface vsc_req_if;
  logic                      valid;
  logic                      ready;
  logic [vsc_pkg::REQ_W-1:0] req_type;
  logic [vsc_pkg::BYTE_W-1:0] in_byte;
  logic [vsc_pkg::VAL_W-1:0] in_value;

  modport source (output valid, req_type, in_byte, in_value, input ready);
  modport sink   (input valid, req_type, in_byte, in_value, output ready);
endinterface

interface vsc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [vsc_pkg::BYTE_W-1:0] out_byte;
  logic                       last;
  logic                       accepted;
  logic                       complete;
  logic [vsc_pkg::VAL_W-1:0]  size_value;
  logic [vsc_pkg::CNT_W-1:0]  byte_count;

  modport source (output valid, out_byte, last, accepted, complete, size_value, byte_count,
                  input ready);
  modport sink   (input valid, out_byte, last, accepted, complete, size_value, byte_count,
                  output ready);
endinterface

// ===== src/vsc_front.sv =====
// ----------------------------------------------------------------------------
// vsc_front
// takes requests, holds the size state and queues one job per request
// ----------------------------------------------------------------------------
module vsc_front #(
  parameter int unsigned MAX_BYTES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [vsc_pkg::REQ_W-1:0]   req_type_i,
  input  logic [vsc_pkg::BYTE_W-1:0]  in_byte_i,
  input  logic [vsc_pkg::VAL_W-1:0]   in_value_i,
  input  logic                        full_i,
  output vsc_pkg::enq_t               enq_o
);
  import vsc_pkg::*;

  localparam logic [CNT_W:0] MaxB = (CNT_W + 1)'(MAX_BYTES);

  logic [VAL_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic             take;
  logic             acc_ok;
  logic             enc;
  logic             stop;
  logic [CNT_W-1:0] n;

  assign ready_o = !full_i;
  assign take    = valid_i && ready_o;
  assign stop    = !in_byte_i[BYTE_W-1];
  assign n       = enc_len(in_value_i);

  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    done_d = done_q;
    acc_ok = 1'b0;
    enc    = 1'b0;
    case (req_type_i)
      REQ_CLEAR: begin
        acc_d  = '0;
        cnt_d  = '0;
        done_d = 1'b0;
        acc_ok = 1'b1;
      end
      REQ_DECODE: begin
        if (!done_q && (stop || ({1'b0, cnt_q} + (CNT_W + 1)'(1) < MaxB))) begin
          acc_d  = {acc_q[VAL_W-CHUNK_W-1:0], in_byte_i[CHUNK_W-1:0]};
          cnt_d  = cnt_q + CNT_W'(1);
          done_d = stop;
          acc_ok = 1'b1;
        end
      end
      REQ_ENCODE: begin
        if ({1'b0, n} <= MaxB) begin
          acc_d  = in_value_i;
          cnt_d  = n;
          done_d = 1'b1;
          acc_ok = 1'b1;
          enc    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    enq_o.push           = take;
    enq_o.job.enc        = enc;
    enq_o.job.accepted   = acc_ok;
    enq_o.job.complete   = done_d;
    enq_o.job.size_value = done_d ? acc_d : '0;
    enq_o.job.byte_count = done_d ? cnt_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (take) begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

endmodule

// ===== src/vsc_queue.sv =====
// ----------------------------------------------------------------------------
// vsc_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module vsc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vsc_pkg::enq_t enq_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output vsc_pkg::job_t head_o
);
  import vsc_pkg::*;

  localparam int unsigned PtrW = $clog2(QDEPTH);
  localparam int unsigned CntW = $clog2(QDEPTH + 1);

  job_t            mem_q [QDEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (enq_i.push) begin
      mem_q[wr_q] <= enq_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (enq_i.push) begin
        wr_q <= (wr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QDEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      case ({enq_i.push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== src/vsc_back.sv =====
// ----------------------------------------------------------------------------
// vsc_back
// expands queued jobs into result beats behind an output register
// ----------------------------------------------------------------------------
module vsc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  vsc_pkg::job_t               head_i,
  output logic                        pop_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [vsc_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        last_o,
  output logic                        accepted_o,
  output logic                        complete_o,
  output logic [vsc_pkg::VAL_W-1:0]   size_value_o,
  output logic [vsc_pkg::CNT_W-1:0]   byte_count_o
);
  import vsc_pkg::*;

  logic               vld_q;
  logic [IDX_W-1:0]   k_q;
  logic [BYTE_W-1:0]  byte_q;
  logic               last_q, acc_q, cmp_q;
  logic [VAL_W-1:0]   val_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               load, fire, is_last;
  logic [IDX_W-1:0]   idx;
  logic [CHUNK_W-1:0] chunk;
  logic [BYTE_W-1:0]  obyte;

  assign load    = !vld_q || ready_i;
  assign fire    = load && !empty_i;
  assign is_last = !head_i.enc || ({1'b0, k_q} + CNT_W'(1) == head_i.byte_count);
  assign pop_o   = fire && is_last;
  assign idx     = IDX_W'(head_i.byte_count - CNT_W'(1) - {1'b0, k_q});

  always_comb begin
    chunk = '0;
    for (int i = 0; i < MAX_CHUNK; i++) begin
      if (idx == IDX_W'(i)) chunk = head_i.size_value[CHUNK_W*i +: CHUNK_W];
    end
    obyte = head_i.enc ? {!is_last, chunk} : '0;
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= obyte;
      last_q <= is_last;
      acc_q  <= head_i.accepted;
      cmp_q  <= head_i.complete;
      val_q  <= head_i.size_value;
      cnt_q  <= head_i.byte_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      k_q   <= '0;
    end else begin
      if (load) begin
        vld_q <= !empty_i;
      end
      if (fire) begin
        k_q <= is_last ? '0 : k_q + IDX_W'(1);
      end
    end
  end

  assign valid_o      = vld_q;
  assign out_byte_o   = byte_q;
  assign last_o       = last_q;
  assign accepted_o   = acc_q;
  assign complete_o   = cmp_q;
  assign size_value_o = val_q;
  assign byte_count_o = cnt_q;

endmodule

// ===== src/vlq_size_codec.sv =====
// ----------------------------------------------------------------------------
// vlq_size_codec
// big-endian 7-bit-per-byte size codec: clear, decode one byte, encode value
// ----------------------------------------------------------------------------
//  port    dir  beat
//  req_i   in   req_type, in_byte, in_value
//  rsp_o   out  out_byte, last, accepted, complete, size_value, byte_count
//
//  a request is taken every cycle while the 2-entry job queue has room
//  clear and decode give 1 beat, encode gives 1 to 8 beats, one per cycle unless stalled
//  beats leave the output register one per cycle while rsp ready is high, so encode length sets rate
//  a taken request is written to the job queue, then its first beat to the output register
//  a stalled result beat holds, the queue fills and req ready drops
//  asynchronous reset clears the size state, queue pointers and the valid bit of the output register
// ----------------------------------------------------------------------------
module vlq_size_codec #(
  parameter int unsigned MAX_BYTES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vsc_req_if.sink      req_i,
  vsc_rsp_if.source    rsp_o
);
  import vsc_pkg::*;

  enq_t enq;
  job_t head;
  logic full, empty, pop;

  vsc_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (req_i.valid),
    .ready_o    (req_i.ready),
    .req_type_i (req_i.req_type),
    .in_byte_i  (req_i.in_byte),
    .in_value_i (req_i.in_value),
    .full_i     (full),
    .enq_o      (enq)
  );

  vsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (enq),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  vsc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .valid_o      (rsp_o.valid),
    .ready_i      (rsp_o.ready),
    .out_byte_o   (rsp_o.out_byte),
    .last_o       (rsp_o.last),
    .accepted_o   (rsp_o.accepted),
    .complete_o   (rsp_o.complete),
    .size_value_o (rsp_o.size_value),
    .byte_count_o (rsp_o.byte_count)
  );

endmodule

// ===== src/vsc_checker.sv =====
// ----------------------------------------------------------------------------
// vsc_checker
// port-level checks on the result channel of the codec
// ----------------------------------------------------------------------------
module vsc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       valid_i,
  input logic                       ready_i,
  input logic [vsc_pkg::BYTE_W-1:0] out_byte_i,
  input logic                       last_i,
  input logic                       accepted_i,
  input logic                       complete_i,
  input logic [vsc_pkg::VAL_W-1:0]  size_value_i,
  input logic [vsc_pkg::CNT_W-1:0]  byte_count_i
);
  import vsc_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(out_byte_i) && $stable(last_i))
    else $error("stalled beat changed");

  a_mid_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !last_i |-> accepted_i && complete_i && out_byte_i[BYTE_W-1])
    else $error("non-final beat is not an encode byte");

  a_final_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && last_i |-> !out_byte_i[BYTE_W-1])
    else $error("final beat has continuation bit");

  a_incomplete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !complete_i |-> size_value_i == '0 && byte_count_i == '0)
    else $error("incomplete size reports data");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && complete_i |-> byte_count_i != '0)
    else $error("complete size with zero bytes");

endmodule

bind vlq_size_codec vsc_checker u_vsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (rsp_o.valid),
  .ready_i      (rsp_o.ready),
  .out_byte_i   (rsp_o.out_byte),
  .last_i       (rsp_o.last),
  .accepted_i   (rsp_o.accepted),
  .complete_i   (rsp_o.complete),
  .size_value_i (rsp_o.size_value),
  .byte_count_i (rsp_o.byte_count)
);
